### rtl/aet_pkg.sv
package aet_pkg;

    // class of one input character, decided in the front part
    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_POINT,
        CC_SPACE,
        CC_OP,
        CC_OPEN,
        CC_CLOSE,
        CC_BAD,
        CC_END
    } t_ccls;

    // token kinds
    localparam logic [2:0] TK_NUMBER   = 3'd0;
    localparam logic [2:0] TK_OPERATOR = 3'd1;
    localparam logic [2:0] TK_OPEN     = 3'd2;
    localparam logic [2:0] TK_CLOSE    = 3'd3;
    localparam logic [2:0] TK_ERROR    = 3'd4;
    localparam logic [2:0] TK_ACCEPTED = 3'd5;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNMATCHED = 3'd1;
    localparam logic [2:0] ERR_POINT     = 3'd2;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd3;
    localparam logic [2:0] ERR_UNCLOSED  = 3'd4;
    localparam logic [2:0] ERR_TOO_DEEP  = 3'd5;

    // fraction digit count saturates here
    localparam logic [3:0] FRAC_MAX = 4'd15;

    // width of the mantissa on the result ports
    localparam int unsigned MANT_OUT_BITS = 32;

    // classified character as it travels from front to back
    typedef struct packed {
        t_ccls       kind;
        logic [3:0]  digit;
        logic [2:0]  op;
    } t_cls;

    // one result token
    typedef struct packed {
        logic [2:0]               token_kind;
        logic [2:0]               op_code;
        logic [MANT_OUT_BITS-1:0] mantissa;
        logic [3:0]               frac_digits;
        logic [2:0]               error_code;
        logic                     last_of_run;
    } t_res;

endpackage

### rtl/aet_front.sv
module aet_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [7:0]    i_char_code,
    input  logic          i_end_marker,
    output logic          o_valid,
    input  logic          i_take,
    output aet_pkg::t_cls o_item
);

    aet_pkg::t_cls cls;
    aet_pkg::t_cls r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          wr;

    // classify the incoming character
    always_comb begin
        cls.kind  = aet_pkg::CC_BAD;
        cls.digit = i_char_code[3:0];
        cls.op    = aet_pkg::OP_ADD;
        if (i_end_marker) begin
            cls.kind = aet_pkg::CC_END;
        end else begin
            case (i_char_code)
                8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: cls.kind = aet_pkg::CC_SPACE;
                8'h2B: begin
                    cls.kind = aet_pkg::CC_OP;
                    cls.op   = aet_pkg::OP_ADD;
                end
                8'h2D: begin
                    cls.kind = aet_pkg::CC_OP;
                    cls.op   = aet_pkg::OP_SUB;
                end
                8'h2A: begin
                    cls.kind = aet_pkg::CC_OP;
                    cls.op   = aet_pkg::OP_MUL;
                end
                8'h2F: begin
                    cls.kind = aet_pkg::CC_OP;
                    cls.op   = aet_pkg::OP_DIV;
                end
                8'h5E: begin
                    cls.kind = aet_pkg::CC_OP;
                    cls.op   = aet_pkg::OP_POW;
                end
                8'h28: cls.kind = aet_pkg::CC_OPEN;
                8'h29: cls.kind = aet_pkg::CC_CLOSE;
                8'h2E: cls.kind = aet_pkg::CC_POINT;
                default: begin
                    if (i_char_code inside {[8'h30:8'h39]}) begin
                        cls.kind = aet_pkg::CC_DIGIT;
                    end
                end
            endcase
        end
    end

    // two-entry queue toward the back part
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rd_ptr];
    assign wr      = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(wr) - 2'(i_take);
        end
    end

endmodule

### rtl/aet_back.sv
module aet_back #(
    parameter int unsigned MANTISSA_BITS = 32,
    parameter int unsigned MAX_DEPTH     = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  aet_pkg::t_cls i_item,
    input  logic          i_space,
    output logic          o_take,
    output logic [1:0]    o_wr_n,
    output aet_pkg::t_res o_res0,
    output aet_pkg::t_res o_res1
);

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned PW = MANTISSA_BITS + 4;

    logic                     r_in_number, n_in_number;
    logic [MANTISSA_BITS-1:0] r_value, n_value;
    logic [3:0]               r_frac, n_frac;
    logic                     r_point, n_point;
    logic [DW-1:0]            r_depth, n_depth;
    logic                     r_failed, n_failed;

    aet_pkg::t_res res [2];
    aet_pkg::t_res num_res;
    logic [1:0]    cnt;
    logic          handled;
    logic [PW-1:0] prod;

    function automatic aet_pkg::t_res mk_tok(input logic [2:0] kind, input logic [2:0] op,
                                             input logic [2:0] err);
        aet_pkg::t_res t;
        t            = '0;
        t.token_kind = kind;
        t.op_code    = op;
        t.error_code = err;
        return t;
    endfunction

    assign o_take = i_valid && i_space;

    // value times ten plus digit, saturation seen in the top four bits
    assign prod = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0} + PW'(i_item.digit);

    // state update and result tokens for one transaction
    always_comb begin
        n_in_number = r_in_number;
        n_value     = r_value;
        n_frac      = r_frac;
        n_point     = r_point;
        n_depth     = r_depth;
        n_failed    = r_failed;
        res[0]      = '0;
        res[1]      = '0;
        cnt         = 2'd0;
        handled     = 1'b0;

        num_res             = '0;
        num_res.token_kind  = aet_pkg::TK_NUMBER;
        num_res.mantissa    = aet_pkg::MANT_OUT_BITS'(r_value);
        num_res.frac_digits = r_frac;

        if (i_item.kind == aet_pkg::CC_END) begin
            if (!r_failed) begin
                if (r_in_number) begin
                    res[cnt[0]] = num_res;
                    cnt         = cnt + 2'd1;
                end
                if (r_depth != '0) begin
                    res[cnt[0]] = mk_tok(aet_pkg::TK_ERROR, aet_pkg::OP_ADD,
                                         aet_pkg::ERR_UNCLOSED);
                end else begin
                    res[cnt[0]] = mk_tok(aet_pkg::TK_ACCEPTED, aet_pkg::OP_ADD,
                                         aet_pkg::ERR_NONE);
                end
                cnt = cnt + 2'd1;
            end
            n_in_number = 1'b0;
            n_value     = '0;
            n_frac      = 4'd0;
            n_point     = 1'b0;
            n_depth     = '0;
            n_failed    = 1'b0;
        end else if (!r_failed) begin
            // number in progress
            if (r_in_number) begin
                if (i_item.kind == aet_pkg::CC_DIGIT) begin
                    handled = 1'b1;
                    if (prod[PW-1 -: 4] != 4'd0) begin
                        n_value = '1;
                    end else begin
                        n_value = prod[MANTISSA_BITS-1:0];
                    end
                    if (r_point && (r_frac < aet_pkg::FRAC_MAX)) begin
                        n_frac = r_frac + 4'd1;
                    end
                end else if (i_item.kind == aet_pkg::CC_POINT) begin
                    handled = 1'b1;
                    if (r_point) begin
                        n_in_number = 1'b0;
                        n_value     = '0;
                        n_frac      = 4'd0;
                        n_point     = 1'b0;
                        n_failed    = 1'b1;
                        res[cnt[0]] = mk_tok(aet_pkg::TK_ERROR, aet_pkg::OP_ADD,
                                             aet_pkg::ERR_POINT);
                        cnt         = cnt + 2'd1;
                    end else begin
                        n_point = 1'b1;
                    end
                end else begin
                    res[cnt[0]] = num_res;
                    cnt         = cnt + 2'd1;
                    n_in_number = 1'b0;
                    n_value     = '0;
                    n_frac      = 4'd0;
                    n_point     = 1'b0;
                end
            end

            // character on its own
            if (!handled) begin
                case (i_item.kind)
                    aet_pkg::CC_SPACE: begin
                    end
                    aet_pkg::CC_OP: begin
                        res[cnt[0]] = mk_tok(aet_pkg::TK_OPERATOR, i_item.op,
                                             aet_pkg::ERR_NONE);
                        cnt         = cnt + 2'd1;
                    end
                    aet_pkg::CC_OPEN: begin
                        if (r_depth >= DW'(MAX_DEPTH)) begin
                            n_failed    = 1'b1;
                            res[cnt[0]] = mk_tok(aet_pkg::TK_ERROR, aet_pkg::OP_ADD,
                                                 aet_pkg::ERR_TOO_DEEP);
                        end else begin
                            n_depth     = r_depth + DW'(1);
                            res[cnt[0]] = mk_tok(aet_pkg::TK_OPEN, aet_pkg::OP_ADD,
                                                 aet_pkg::ERR_NONE);
                        end
                        cnt = cnt + 2'd1;
                    end
                    aet_pkg::CC_CLOSE: begin
                        if (r_depth == '0) begin
                            n_failed    = 1'b1;
                            res[cnt[0]] = mk_tok(aet_pkg::TK_ERROR, aet_pkg::OP_ADD,
                                                 aet_pkg::ERR_UNMATCHED);
                        end else begin
                            n_depth     = r_depth - DW'(1);
                            res[cnt[0]] = mk_tok(aet_pkg::TK_CLOSE, aet_pkg::OP_ADD,
                                                 aet_pkg::ERR_NONE);
                        end
                        cnt = cnt + 2'd1;
                    end
                    aet_pkg::CC_DIGIT: begin
                        n_in_number = 1'b1;
                        n_value     = MANTISSA_BITS'(i_item.digit);
                        n_frac      = 4'd0;
                        n_point     = 1'b0;
                    end
                    default: begin
                        n_failed    = 1'b1;
                        res[cnt[0]] = mk_tok(aet_pkg::TK_ERROR, aet_pkg::OP_ADD,
                                             aet_pkg::ERR_BAD_CHAR);
                        cnt         = cnt + 2'd1;
                    end
                endcase
            end
        end

        // mark the final token of this transaction
        if (cnt == 2'd1) begin
            res[0].last_of_run = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last_of_run = 1'b1;
        end
    end

    assign o_wr_n = o_take ? cnt : 2'd0;
    assign o_res0 = res[0];
    assign o_res1 = res[1];

    // tokenizer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_value     <= '0;
            r_frac      <= 4'd0;
            r_point     <= 1'b0;
            r_depth     <= '0;
            r_failed    <= 1'b0;
        end else if (o_take) begin
            r_in_number <= n_in_number;
            r_value     <= n_value;
            r_frac      <= n_frac;
            r_point     <= n_point;
            r_depth     <= n_depth;
            r_failed    <= n_failed;
        end
    end

    // end marker leaves a clean state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.kind == aet_pkg::CC_END) |=>
        (!r_failed && !r_in_number && r_depth == '0))
        else $error("state not cleared after end marker");

    // a point mark only lives inside a number
    a_point_in_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point |-> r_in_number)
        else $error("point mark outside a number");

    // a failed expression keeps no number
    a_failed_no_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !r_in_number)
        else $error("number kept after failure");

    // nothing comes out while failed, not even at the end marker
    a_failed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_failed) |-> (o_wr_n == 2'd0))
        else $error("token written while failed");

endmodule

### rtl/aet_outq.sv
module aet_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_wr_n,
    input  aet_pkg::t_res i_res0,
    input  aet_pkg::t_res i_res1,
    output logic          o_space,
    output logic          o_empty,
    input  logic          i_pop,
    output aet_pkg::t_res o_res
);

    aet_pkg::t_res r_mem [4];
    logic [1:0]    r_wr_ptr;
    logic [1:0]    r_rd_ptr;
    logic [2:0]    r_count;
    logic          rd;

    assign o_space = (r_count <= 3'd2);
    assign o_empty = (r_count == 3'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign rd      = i_pop && !o_empty;

    // up to two tokens written per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_wr_n == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_wr_n;
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + 3'(i_wr_n) - 3'(rd);
        end
    end

endmodule

### rtl/arith_expr_tokenizer_top.sv
// channel   direction  handshake          payload
// input     in         push / full        i_char_code, i_end_marker
// result    out        empty / pop        o_token_kind, o_op_code, o_mantissa,
//                                         o_frac_digits, o_error_code, o_last_of_run
//
// one character per cycle is taken while not full; it is classified into a
// two-entry queue and the tokenizer state is updated in the next stage, one
// character per cycle. a character gives up to two tokens in one cycle into
// a four-entry result queue; the back stage waits while fewer than two result
// slots are free. first token comes via the input queue, then the result queue.
// reset is synchronous, active low, and clears queues and tokenizer state.
module arith_expr_tokenizer_top #(
    parameter int unsigned MANTISSA_BITS = 32,
    parameter int unsigned MAX_DEPTH     = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_marker,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_token_kind,
    output logic [2:0]  o_op_code,
    output logic [31:0] o_mantissa,
    output logic [3:0]  o_frac_digits,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run
);

    aet_pkg::t_cls item;
    logic          item_valid;
    logic          take;
    logic          space;
    logic [1:0]    wr_n;
    aet_pkg::t_res res0;
    aet_pkg::t_res res1;
    aet_pkg::t_res res_out;

    // classification and input queue
    aet_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .o_valid      (item_valid),
        .i_take       (take),
        .o_item       (item)
    );

    // tokenizer state machine
    aet_back #(
        .MANTISSA_BITS (MANTISSA_BITS),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .i_space (space),
        .o_take  (take),
        .o_wr_n  (wr_n),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    // result queue
    aet_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_n  (wr_n),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_space (space),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    assign o_token_kind  = res_out.token_kind;
    assign o_op_code     = res_out.op_code;
    assign o_mantissa    = res_out.mantissa;
    assign o_frac_digits = res_out.frac_digits;
    assign o_error_code  = res_out.error_code;
    assign o_last_of_run = res_out.last_of_run;

endmodule

### bench/aet_checker.sv
module aet_checker #(
    parameter int unsigned MANTISSA_BITS = 32,
    parameter int unsigned MAX_DEPTH     = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_marker,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [2:0]  i_token_kind,
    input  logic [2:0]  i_op_code,
    input  logic [31:0] i_mantissa,
    input  logic [3:0]  i_frac_digits,
    input  logic [2:0]  i_error_code,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_live_items
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MANT_LIMIT =
        (MANTISSA_BITS >= 64) ? '1 : ((64'd1 << MANTISSA_BITS) - 64'd1);

    // operator field value when the token is not an operator
    localparam logic [2:0] OP_NONE = 3'd0;

    // characters with a meaning of their own
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_POINT = ".";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_CARET = "^";
    localparam logic [7:0] CH_OPEN  = "(";
    localparam logic [7:0] CH_CLOSE = ")";
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // predicted lexer state
    logic        in_num;
    logic [63:0] num_val;
    logic [3:0]  frac_cnt;
    logic        pt_seen;
    int unsigned depth;
    logic        halted;

    aet_pkg::t_res tokens_due[$];
    aet_pkg::t_res step_toks[$];
    aet_pkg::t_res got;
    aet_pkg::t_res want;
    int            mismatches;
    int            live_items;

    assign o_fail_count = mismatches;
    assign o_live_items = live_items;

    function automatic aet_pkg::t_res make_tok(logic [2:0] kind, logic [2:0] op,
                                               logic [63:0] mant, logic [3:0] frac,
                                               logic [2:0] err);
        aet_pkg::t_res t;
        t.token_kind  = kind;
        t.op_code     = op;
        t.mantissa    = 32'(mant & MANT_LIMIT);
        t.frac_digits = frac;
        t.error_code  = err;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    task automatic drop_number();
        in_num   = 1'b0;
        num_val  = '0;
        frac_cnt = '0;
        pt_seen  = 1'b0;
    endtask

    task automatic raise_error(logic [2:0] code);
        drop_number();
        halted = 1'b1;
        step_toks.push_back(make_tok(aet_pkg::TK_ERROR, OP_NONE, '0, '0, code));
    endtask

    task automatic emit_number();
        step_toks.push_back(make_tok(aet_pkg::TK_NUMBER, OP_NONE, num_val, frac_cnt,
                                     aet_pkg::ERR_NONE));
    endtask

    task automatic emit_simple(logic [2:0] kind, logic [2:0] op);
        step_toks.push_back(make_tok(kind, op, '0, '0, aet_pkg::ERR_NONE));
    endtask

    // mantissa and fraction count saturate independently
    task automatic take_digit(logic [3:0] d);
        if (num_val > (MANT_LIMIT - 64'(d)) / 64'd10) begin
            num_val = MANT_LIMIT;
        end else begin
            num_val = num_val * 64'd10 + 64'(d);
        end
        if (pt_seen && frac_cnt < aet_pkg::FRAC_MAX) begin
            frac_cnt = frac_cnt + 4'd1;
        end
    endtask

    // tokens caused by one accepted character
    task automatic tokenize(logic [7:0] c, logic e);
        logic          handled;
        logic          digit;
        aet_pkg::t_res tail;
        step_toks.delete();
        digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        handled = 1'b0;
        if (e) begin
            if (!halted) begin
                if (in_num) begin
                    emit_number();
                end
                if (depth != 0) begin
                    step_toks.push_back(make_tok(aet_pkg::TK_ERROR, OP_NONE, '0, '0,
                                                 aet_pkg::ERR_UNCLOSED));
                end else begin
                    emit_simple(aet_pkg::TK_ACCEPTED, OP_NONE);
                end
            end
            drop_number();
            depth  = 0;
            halted = 1'b0;
        end else if (!halted) begin
            // a number goes on over digits and one point
            if (in_num) begin
                if (digit) begin
                    take_digit(4'(c - CH_ZERO));
                    handled = 1'b1;
                end else if (c == CH_POINT) begin
                    if (pt_seen) begin
                        raise_error(aet_pkg::ERR_POINT);
                    end else begin
                        pt_seen = 1'b1;
                    end
                    handled = 1'b1;
                end else begin
                    emit_number();
                    drop_number();
                end
            end
            if (!handled) begin
                case (c)
                    CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE: begin
                    end
                    CH_PLUS:  emit_simple(aet_pkg::TK_OPERATOR, aet_pkg::OP_ADD);
                    CH_MINUS: emit_simple(aet_pkg::TK_OPERATOR, aet_pkg::OP_SUB);
                    CH_STAR:  emit_simple(aet_pkg::TK_OPERATOR, aet_pkg::OP_MUL);
                    CH_SLASH: emit_simple(aet_pkg::TK_OPERATOR, aet_pkg::OP_DIV);
                    CH_CARET: emit_simple(aet_pkg::TK_OPERATOR, aet_pkg::OP_POW);
                    CH_OPEN: begin
                        if (depth >= MAX_DEPTH) begin
                            raise_error(aet_pkg::ERR_TOO_DEEP);
                        end else begin
                            depth = depth + 1;
                            emit_simple(aet_pkg::TK_OPEN, OP_NONE);
                        end
                    end
                    CH_CLOSE: begin
                        if (depth == 0) begin
                            raise_error(aet_pkg::ERR_UNMATCHED);
                        end else begin
                            depth = depth - 1;
                            emit_simple(aet_pkg::TK_CLOSE, OP_NONE);
                        end
                    end
                    default: begin
                        if (digit) begin
                            drop_number();
                            in_num  = 1'b1;
                            num_val = 64'(c - CH_ZERO);
                        end else begin
                            raise_error(aet_pkg::ERR_BAD_CHAR);
                        end
                    end
                endcase
            end
        end
        // mark the final token of this character
        if (step_toks.size() > 0) begin
            tail = step_toks.pop_back();
            tail.last_of_run = 1'b1;
            step_toks.push_back(tail);
        end
        foreach (step_toks[i]) begin
            tokens_due.push_back(step_toks[i]);
        end
    endtask

    task automatic report_mismatch(string what, aet_pkg::t_res exp_tok,
                                   aet_pkg::t_res act_tok);
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
            $display("%0t %s: expected kind %0d op %0d mant %0d frac %0d err %0d last %0d",
                     $realtime, what, exp_tok.token_kind, exp_tok.op_code, exp_tok.mantissa,
                     exp_tok.frac_digits, exp_tok.error_code, exp_tok.last_of_run);
            $display("%0t %s: actual   kind %0d op %0d mant %0d frac %0d err %0d last %0d",
                     $realtime, what, act_tok.token_kind, act_tok.op_code, act_tok.mantissa,
                     act_tok.frac_digits, act_tok.error_code, act_tok.last_of_run);
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drop_number();
            depth      = 0;
            halted     = 1'b0;
            mismatches = 0;
            live_items = 0;
            tokens_due.delete();
        end else begin
            // input transaction
            if (i_push && !i_full) begin
                if (!halted || i_end_marker) begin
                    live_items = live_items + 1;
                end
                tokenize(i_char_code, i_end_marker);
            end
            // result transaction
            if (i_pop && !i_empty) begin
                got.token_kind  = i_token_kind;
                got.op_code     = i_op_code;
                got.mantissa    = i_mantissa;
                got.frac_digits = i_frac_digits;
                got.error_code  = i_error_code;
                got.last_of_run = i_last_of_run;
                if (tokens_due.size() == 0) begin
                    report_mismatch("unexpected token", '0, got);
                end else begin
                    want = tokens_due.pop_front();
                    if (got.token_kind !== want.token_kind || got.op_code !== want.op_code
                        || got.mantissa !== want.mantissa
                        || got.frac_digits !== want.frac_digits
                        || got.error_code !== want.error_code
                        || got.last_of_run !== want.last_of_run) begin
                        report_mismatch("token mismatch", want, got);
                    end
                end
            end
        end
        o_pending <= tokens_due.size();
    end

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MANT_W         = 32;
    localparam int unsigned DEPTH_LIMIT    = 255;
    localparam int          LIVE_PER_PHASE = 425;
    localparam int          TAIL_CYCLES    = 20;

    // idle and stall percentages of each phase
    localparam int PHASE_IDLE  [4] = '{0, 88, 0, 27};
    localparam int PHASE_STALL [4] = '{0, 0, 88, 27};

    localparam logic [7:0] WS_CODES [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    localparam logic [7:0] OP_CHARS [5] = '{"+", "-", "*", "/", "^"};
    localparam string      NOISE_CHARS  = "0123456789.+-*/^() \t";

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_char_code;
    logic        i_end_marker;
    logic        empty;
    logic        pop;
    logic [2:0]  o_token_kind;
    logic [2:0]  o_op_code;
    logic [31:0] o_mantissa;
    logic [3:0]  o_frac_digits;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    int fail_count;
    int pending;
    int live_items;
    int send_idle;
    int recv_stall;

    logic [7:0] text_q[$];

    arith_expr_tokenizer_top #(
        .MANTISSA_BITS(MANT_W),
        .MAX_DEPTH    (DEPTH_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .empty        (empty),
        .pop          (pop),
        .o_token_kind (o_token_kind),
        .o_op_code    (o_op_code),
        .o_mantissa   (o_mantissa),
        .o_frac_digits(o_frac_digits),
        .o_error_code (o_error_code),
        .o_last_of_run(o_last_of_run)
    );

    aet_checker #(
        .MANTISSA_BITS(MANT_W),
        .MAX_DEPTH    (DEPTH_LIMIT)
    ) token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_token_kind (o_token_kind),
        .i_op_code    (o_op_code),
        .i_mantissa   (o_mantissa),
        .i_frac_digits(o_frac_digits),
        .i_error_code (o_error_code),
        .i_last_of_run(o_last_of_run),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live_items (live_items)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver stalls at random
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(0, 99) >= recv_stall);
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic put_char(logic [7:0] c, logic e);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_char_code  <= c;
        i_end_marker <= e;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic end_expr();
        put_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i], 1'b0);
        end
        end_expr();
    endtask

    task automatic flush_text();
        while (text_q.size() > 0) begin
            put_char(text_q.pop_front(), 1'b0);
        end
        end_expr();
    endtask

    // hold the sender until every token has come out
    task automatic drain_tokens();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic add_gap();
        if ($urandom_range(0, 99) < 15) begin
            text_q.push_back(WS_CODES[$urandom_range(0, 5)]);
        end
    endtask

    function automatic logic is_token_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || c == "." || c == "+" || c == "-" || c == "*"
            || c == "/" || c == "^" || c == "(" || c == ")" || (c >= 8'd9 && c <= 8'd13)
            || c == 8'd32;
    endfunction

    // mostly short numbers, some long enough to saturate
    task automatic add_number();
        int r;
        int nd;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0: add_str("4294967295");
                1: add_str("4294967296");
                2: add_str("99999999999");
                default: add_str("429496729");
            endcase
        end else begin
            nd = (r < 88) ? $urandom_range(1, 4) : $urandom_range(10, 14);
            repeat (nd) text_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 99) < 35) begin
            text_q.push_back(".");
            nd = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(14, 18);
            repeat (nd) text_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    // well-formed expression; a few are left with brackets open
    task automatic add_expr(output int opens);
        int terms;
        int k;
        opens = 0;
        terms = $urandom_range(1, 6);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) begin
                text_q.push_back(OP_CHARS[$urandom_range(0, 4)]);
                add_gap();
            end
            k = $urandom_range(0, 99);
            k = (k < 65) ? 0 : (k < 90) ? 1 : 2;
            repeat (k) begin
                text_q.push_back("(");
                add_gap();
            end
            opens = opens + k;
            add_number();
            add_gap();
            k = $urandom_range(0, opens);
            repeat (k) text_q.push_back(")");
            opens = opens - k;
        end
        if ($urandom_range(0, 9) != 0) begin
            repeat (opens) text_q.push_back(")");
            opens = 0;
        end
    endtask

    // break the expression, then trail some characters that get ignored
    task automatic add_fault(int opens);
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: repeat (opens + 1) text_q.push_back(")");
            1: add_str(" 5.1.");
            2: begin
                do c = 8'($urandom_range(0, 255)); while (is_token_char(c));
                text_q.push_back(c);
            end
            default: add_str(" .");
        endcase
        repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 1) != 0) begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_q.push_back(NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)]);
            end
        end
    endtask

    // nesting to the depth limit, then one more open or a full unwind
    task automatic send_deep(logic overflow);
        repeat (DEPTH_LIMIT) text_q.push_back("(");
        if (overflow) begin
            text_q.push_back("(");
            text_q.push_back("1");
        end else begin
            add_number();
            repeat (DEPTH_LIMIT) text_q.push_back(")");
        end
        flush_text();
    endtask

    task automatic send_random_expr();
        int pick;
        int opens;
        pick = $urandom_range(0, 199);
        if (pick == 0) begin
            send_deep(1'($urandom_range(0, 1)));
        end else begin
            if (pick < 120) begin
                add_expr(opens);
            end else if (pick < 160) begin
                add_expr(opens);
                add_fault(opens);
            end else begin
                add_noise();
            end
            flush_text();
        end
        if ($urandom_range(0, 49) == 0) begin
            drain_tokens();
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_char_code  = '0;
        i_end_marker = 1'b0;
        send_idle    = 0;
        recv_stall   = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: operators other than plus, point cases, bracket errors, code extremes
        send_text("(2.5\t-3)*0/9.^1");
        send_text(")");
        send_text("1.2.");
        put_char("(", 1'b0);
        put_char("(", 1'b0);
        put_char(8'hFF, 1'b0);
        end_expr();
        send_text(".");
        put_char(8'h00, 1'b0);
        end_expr();
        send_text("(");
        drain_tokens();

        // random phases with different idle and stall rates
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = PHASE_IDLE[ph];
            recv_stall = PHASE_STALL[ph];
            if (ph == 2) begin
                send_deep(1'b1);
                send_deep(1'b0);
            end
            while (live_items < (ph + 1) * LIVE_PER_PHASE) begin
                send_random_expr();
            end
            drain_tokens();
        end

        recv_stall = 0;
        drain_tokens();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/aet_pkg.sv
rtl/aet_front.sv
rtl/aet_back.sv
rtl/aet_outq.sv
rtl/arith_expr_tokenizer_top.sv
bench/aet_checker.sv
bench/tb.sv
